FILE: hw/rtl/rcmv_pkg.sv
// shared constants and types for the rnn cell matrix-vector unit
package rcmv_pkg;

    localparam int DEF_MAX_INPUT  = 64;
    localparam int DEF_MAX_HIDDEN = 64;

    localparam int WSTORE_DEPTH = 8192;
    localparam int WA_W         = 13;
    localparam int VAL_W        = 16;
    localparam int ACC_W        = 40;
    localparam int PROD_W       = 32;
    localparam int SIZE_W       = 7;
    localparam int IDX_W        = 6;
    localparam int FRAC_W       = 12;

    // command codes
    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_FEATURE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // register indexes
    localparam logic REG_INPUT_SIZE  = 1'b0;
    localparam logic REG_HIDDEN_SIZE = 1'b1;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ORD   = 5'b01000,
        ST_OWR   = 5'b10000
    } t_state;

endpackage

FILE: hw/rtl/rnn_cell_matvec_bias.sv
// top level of the rnn cell matrix-vector product with bias
// Weight and bias words are written straight into their memories. The
// accumulators sit in a ring of MAX_HIDDEN cells
// that rotates once per feature past a single multiply-accumulate fed by the
// weight memory read port. After the last feature of a vector the ring
// rotates hidden_size more steps, each result going through a bias memory
// read and then the output register, and all accumulators are cleared. Words are not
// accepted while a feature or the result burst is in progress.
module rnn_cell_matvec_bias import rcmv_pkg::*; #(
    parameter int MAX_INPUT  = DEF_MAX_INPUT,
    parameter int MAX_HIDDEN = DEF_MAX_HIDDEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // address[12:0], value[28:13]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_index[5:0], out_value[21:6]
    output logic        m_axis_tlast   // out_last
);

    localparam int H_CW  = $clog2(MAX_HIDDEN + 1);
    localparam int TOT_W = $clog2(MAX_INPUT + MAX_HIDDEN + 1);
    localparam int H_AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;

    t_state r_state, n_state;
    logic [SIZE_W-1:0] r_in, r_hid;
    logic [TOT_W-1:0]  r_fc;
    logic [H_CW-1:0]   r_ic, r_oj;
    logic [WA_W-1:0]   r_waddr;
    logic signed [VAL_W-1:0] r_feat;
    logic r_v1, r_v2, r_en1;
    logic r_ovalid, r_olast;
    logic [IDX_W-1:0] r_oidx;
    logic [VAL_W-1:0] r_oval;

    logic [TOT_W-1:0] w_ni, w_tot;
    logic [H_CW-1:0]  w_nh;
    logic w_cfg_wr, w_in_acc, w_clr, w_out_go;
    t_cmd w_cmd;
    logic [WA_W-1:0]  w_addr;
    logic [VAL_W-1:0] w_val;
    logic [VAL_W-1:0] w_wdata, w_bdata;
    logic [ACC_W-1:0] w_chain [MAX_HIDDEN];
    logic [ACC_W-1:0] w_head, w_sum, w_feed, w_biased;
    logic signed [ACC_W-FRAC_W-1:0] w_shr;
    logic [VAL_W-1:0] w_sat;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_HIDDEN_SIZE) ? {25'd0, r_hid} : {25'd0, r_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in  <= SIZE_W'(64);
            r_hid <= SIZE_W'(64);
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_INPUT_SIZE) begin
                r_in <= pwdata[SIZE_W-1:0];
            end else begin
                r_hid <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // effective sizes clamped to the supported range
    always_comb begin
        if (r_in == '0) begin
            w_ni = TOT_W'(1);
        end else if (int'(r_in) > MAX_INPUT) begin
            w_ni = TOT_W'(MAX_INPUT);
        end else begin
            w_ni = TOT_W'(r_in);
        end
        if (r_hid == '0) begin
            w_nh = H_CW'(1);
        end else if (int'(r_hid) > MAX_HIDDEN) begin
            w_nh = H_CW'(MAX_HIDDEN);
        end else begin
            w_nh = H_CW'(r_hid);
        end
    end
    assign w_tot = w_ni + TOT_W'(w_nh);

    // input word fields
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign w_addr   = s_axis_tdata[WA_W-1:0];
    assign w_val    = s_axis_tdata[WA_W+VAL_W-1:WA_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_out_go = (r_state == ST_OWR) && (!r_ovalid || m_axis_tready);

    // memories
    rcmv_ram #(.WIDTH(VAL_W), .AW(WA_W)) u_wram (
        .i_clk  (i_clk),
        .i_we   (w_in_acc && (w_cmd == CMD_WEIGHT)),
        .i_waddr(w_addr),
        .i_wdata(w_val),
        .i_raddr(r_waddr),
        .o_rdata(w_wdata)
    );

    rcmv_ram #(.WIDTH(VAL_W), .AW(H_AW)) u_bram (
        .i_clk  (i_clk),
        .i_we   (w_in_acc && (w_cmd == CMD_BIAS) && (int'(w_addr) < MAX_HIDDEN)),
        .i_waddr(w_addr[H_AW-1:0]),
        .i_wdata(w_val),
        .i_raddr(r_oj[H_AW-1:0]),
        .o_rdata(w_bdata)
    );

    // accumulator ring, head is the last cell
    assign w_head = w_chain[MAX_HIDDEN-1];
    assign w_feed = (r_state == ST_OWR) ? w_head : w_sum;
    assign w_clr  = w_cfg_wr || (w_out_go && (r_oj == w_nh - H_CW'(1)));

    rcmv_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (r_en1),
        .i_weight(w_wdata),
        .i_feat  (r_feat),
        .i_acc   (w_head),
        .o_sum   (w_sum)
    );

    for (genvar k = 0; k < MAX_HIDDEN; k++) begin : g_cell
        logic [ACC_W-1:0] w_in;
        if (k == 0) begin : g_first
            assign w_in = w_feed;
        end else begin : g_rest
            assign w_in = w_chain[k-1];
        end
        rcmv_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clr  (w_clr),
            .i_shift(r_v2 || w_out_go),
            .i_acc  (w_in),
            .o_acc  (w_chain[k])
        );
    end

    // result: add bias, floor shift, saturate
    assign w_biased = w_head + {{(ACC_W-VAL_W-FRAC_W){w_bdata[VAL_W-1]}}, w_bdata,
                                {FRAC_W{1'b0}}};
    assign w_shr    = w_biased[ACC_W-1:FRAC_W];
    always_comb begin
        if (w_shr > $signed((ACC_W-FRAC_W)'(32767))) begin
            w_sat = VAL_W'(16'h7fff);
        end else if (w_shr < -$signed((ACC_W-FRAC_W)'(32768))) begin
            w_sat = VAL_W'(16'h8000);
        end else begin
            w_sat = w_shr[VAL_W-1:0];
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_cmd == CMD_FEATURE)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (int'(r_ic) == MAX_HIDDEN - 1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = (r_fc + TOT_W'(1) == w_tot) ? ST_ORD : ST_IDLE;
                end
            end
            ST_ORD: n_state = ST_OWR;
            ST_OWR: begin
                if (w_out_go) begin
                    n_state = (r_oj == w_nh - H_CW'(1)) ? ST_IDLE : ST_ORD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fc    <= '0;
            r_ic    <= '0;
            r_oj    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_en1   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_ACC);
            r_en1   <= (r_state == ST_ACC) && (r_ic < w_nh);
            r_v2    <= r_v1;
            if (r_state == ST_ACC) begin
                r_ic <= r_ic + H_CW'(1);
            end else begin
                r_ic <= '0;
            end
            if (w_cfg_wr || w_clr) begin
                r_fc <= '0;
            end else if ((r_state == ST_DRAIN) && !r_v1 && !r_v2) begin
                r_fc <= r_fc + TOT_W'(1);
            end
            if (w_clr) begin
                r_oj <= '0;
            end else if (w_out_go) begin
                r_oj <= r_oj + H_CW'(1);
            end
        end
    end

    // weight address walk and held feature word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_waddr <= WA_W'(r_fc);
            r_feat  <= w_val;
        end else if (r_state == ST_ACC) begin
            r_waddr <= r_waddr + WA_W'(w_tot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_go) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_oidx  <= IDX_W'(r_oj);
            r_oval  <= w_sat;
            r_olast <= (r_oj == w_nh - H_CW'(1));
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oval, r_oidx};
    assign m_axis_tlast  = r_olast;

`ifndef ASSERT_OFF
    // last word carries the final row index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (H_CW'(m_axis_tdata[IDX_W-1:0]) == w_nh - H_CW'(1)))
        else $error("last flag on wrong row");
    // ring only moves in accumulate, drain or output states
    a_shift_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_state == ST_ACC) || (r_state == ST_DRAIN)))
        else $error("ring shift outside accumulate");
    // feature count never reaches the vector length while idle
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fc < w_tot))
        else $error("feature count out of range");
`endif

endmodule

FILE: hw/rtl/rcmv_ram.sv
// generic single write port ram with registered read
module rcmv_ram import rcmv_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int AW    = 13
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rcmv_cell.sv
// one accumulator cell of the rotating chain
module rcmv_cell import rcmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_shift,
    input  logic [ACC_W-1:0] i_acc,
    output logic [ACC_W-1:0] o_acc
);

    logic [ACC_W-1:0] r_acc;

    // take the neighbor's value on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc <= '0;
        end else if (i_shift) begin
            r_acc <= i_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hw/rtl/rcmv_mac.sv
// registered weight times feature product and the add into the chain head
module rcmv_mac import rcmv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [VAL_W-1:0] i_weight,
    input  logic signed [VAL_W-1:0] i_feat,
    input  logic        [ACC_W-1:0] i_acc,
    output logic        [ACC_W-1:0] o_sum
);

    logic signed [PROD_W-1:0] r_prod;

    // product stage, rows past the active count add zero
    always_ff @(posedge i_clk) begin
        r_prod <= i_en ? PROD_W'(i_weight * i_feat) : '0;
    end

    assign o_sum = i_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

endmodule
